FILE: sv/gcp_pkg.sv
// shared constants, types and helper functions of the gaussian cdf pipeline
package gcp_pkg;

    // restoring divider steps per register stage
    localparam int DIV_STEPS = 5;

    // internal fixed point, 32 fraction bits
    localparam int QF = 32;
    localparam int ZW = 35;          // |z|, 3 integer bits
    localparam int TW = 33;          // t, up to one
    localparam int D2W = 35;         // twice the reciprocal denominator
    localparam int WW = 37;          // z*z/2
    localparam int UW = 38;          // w*log2(e)
    localparam int NW = 6;           // integer part of u
    localparam int YW = 32;          // reduced exponent argument
    localparam int HW = 36;          // signed horner value
    localparam int PW = 35;          // clamped polynomial
    localparam int SUMW = 34;        // taylor partial sums
    localparam int EW = 33;          // exp result
    localparam int M1W = 33;
    localparam int M2W = 34;
    localparam int QPW = 37;         // final product
    localparam int TAYLOR_TERMS = 13;
    localparam int RECIP_SHIFT = 36;
    localparam int EXP_FLUSH = 40;

    localparam logic [63:0] ONE = 64'd1 << QF;
    localparam logic [63:0] CB1 = ((64'd319381530 << 32) + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] CB2 = ((64'd356563782 << 32) + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] CB3 = ((64'd1781477937 << 32) + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] CB4 = ((64'd1821255978 << 32) + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] CB5 = ((64'd1330274429 << 32) + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] CP = ((64'd231641900 << 32) + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] CC = ((64'd398942280 << 32) + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] CLOG2E = ((64'd1442695041 << 32) + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] CLN2 = ((64'd693147181 << 32) + 64'd500000000) / 64'd1000000000;

    localparam logic signed [HW-1:0] HB1 = HW'(CB1);
    localparam logic signed [HW-1:0] HB2 = HW'(CB2);
    localparam logic signed [HW-1:0] HB3 = HW'(CB3);
    localparam logic signed [HW-1:0] HB4 = HW'(CB4);
    localparam logic signed [HW-1:0] HB5 = HW'(CB5);

    typedef struct packed {
        logic nonneg;
        logic bad;
        logic tail;
    } flags_t;

    // t times a signed horner value, truncated toward zero
    function automatic logic signed [HW-1:0] tmul(logic [TW-1:0] t, logic signed [HW-1:0] h);
        logic [HW-1:0] hm;
        logic [TW+HW-1:0] prod;
        logic [HW-1:0] pm;
        hm = h[HW-1] ? (HW'(0) - h) : h;
        prod = (TW+HW)'(t) * (TW+HW)'(hm);
        pm = prod[QF+HW-1:QF];
        return h[HW-1] ? $signed(HW'(0) - pm) : $signed(pm);
    endfunction

    // fix up a reciprocal quotient estimate that may be one low
    function automatic logic [TW-1:0] div_fix(logic [TW-1:0] q0, logic [31:0] p,
                                              logic [3:0] k);
        logic [TW+3:0] qk;
        logic [TW+3:0] rr;
        qk = (TW+4)'(q0) * (TW+4)'(k);
        rr = (TW+4)'(p) - qk;
        return (rr >= (TW+4)'(k)) ? TW'(q0 + 1'b1) : q0;
    endfunction

endpackage

FILE: sv/gcp_divu.sv
// pipelined restoring divider, a few quotient bits per stage
module gcp_divu #(
    parameter int RW = 35,
    parameter int QW = 35,
    parameter int SBW = 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [RW-1:0]  in_rem,
    input  logic [RW-1:0]  in_div,
    input  logic [SBW-1:0] in_side,
    output logic           out_valid,
    output logic [QW-1:0]  out_quo,
    output logic [SBW-1:0] out_side
);
    localparam int SPS = gcp_pkg::DIV_STEPS;
    localparam int NST = (QW + SPS - 1) / SPS;

    logic           v_reg  [NST];
    logic [RW-1:0]  r_reg  [NST];
    logic [RW-1:0]  d_reg  [NST];
    logic [QW-1:0]  q_reg  [NST];
    logic [SBW-1:0] sb_reg [NST];

    for (genvar s = 0; s < NST; s++) begin : g_st
        logic           vi;
        logic [RW-1:0]  ri;
        logic [RW-1:0]  di;
        logic [QW-1:0]  qi;
        logic [SBW-1:0] sbi;
        logic [RW-1:0]  r_next;
        logic [QW-1:0]  q_next;

        if (s == 0) begin : g_first
            assign vi  = in_valid;
            assign ri  = in_rem;
            assign di  = in_div;
            assign qi  = '0;
            assign sbi = in_side;
        end else begin : g_rest
            assign vi  = v_reg[s-1];
            assign ri  = r_reg[s-1];
            assign di  = d_reg[s-1];
            assign qi  = q_reg[s-1];
            assign sbi = sb_reg[s-1];
        end

        always_comb begin
            logic [RW:0] rs;
            r_next = ri;
            q_next = qi;
            rs = '0;
            for (int j = 0; j < SPS; j++) begin
                if (s * SPS + j < QW) begin
                    rs = {r_next, 1'b0};
                    if (rs >= {1'b0, di}) begin
                        r_next = RW'(rs - {1'b0, di});
                        q_next = {q_next[QW-2:0], 1'b1};
                    end else begin
                        r_next = rs[RW-1:0];
                        q_next = {q_next[QW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= vi;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[s]  <= r_next;
                d_reg[s]  <= di;
                q_reg[s]  <= q_next;
                sb_reg[s] <= sbi;
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_quo   = q_reg[NST-1];
    assign out_side  = sb_reg[NST-1];

endmodule

FILE: sv/gaussian_cdf_poly.sv
// top level of the gaussian cdf pipeline
// Cumulative normal probability P(X <= x) for X ~ N(mean, sd^2), Abramowitz-Stegun
// 26.2.17. A request carries x, mean and sd as signed fixed point words of
// DATA_WIDTH bits (the fraction width cancels in (x-mean)/sd, so any binary
// point works); the result is an unsigned Q0.32 probability with all ones for one,
// and bad_deviation set with probability 0 when sd is zero or negative. Far tails
// (|x-mean| >= 8 sd) return 0 or all ones. The block is a fully pipelined datapath:
// one request is taken every cycle. Its stages include two pipelined restoring
// dividers (|z| and t, seven stages each, up to five quotient bits a stage), four
// horner multiply stages, the thirteen-term taylor series of exp (two multiplier
// stages per term) and the final product chain.
// The whole pipeline advances together and holds while a result waits on m_tready.
module gaussian_cdf_poly #(
    parameter int DATA_WIDTH = 32,
    localparam int S_TDATA_W = ((3 * DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // sample_value, dist_mean, dist_sd (lowest bits first)
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // probability
    output logic [31:0]          m_tdata,
    // bad_deviation
    output logic [0:0]           m_tuser
);
    localparam int DW = DATA_WIDTH;
    localparam int SW = DATA_WIDTH + 2;
    localparam int TW = gcp_pkg::TW;
    localparam int NT = gcp_pkg::TAYLOR_TERMS;
    localparam int RS = gcp_pkg::RECIP_SHIFT;
    localparam int FLW = $bits(gcp_pkg::flags_t);

    // one pipeline-wide advance: the output register is free or being emptied
    logic adv;
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- input stage: difference, sign, tail and error flags
    logic [DW-1:0]   xv, mv, sv;
    logic [DW:0]     diff, ndiff;
    logic [DW-1:0]   mag;
    logic [SW-1:0]   sdiv;
    gcp_pkg::flags_t in_fl;

    assign xv = s_tdata[DW-1:0];
    assign mv = s_tdata[2*DW-1:DW];
    assign sv = s_tdata[3*DW-1:2*DW];

    always_comb begin
        diff = {xv[DW-1], xv} - {mv[DW-1], mv};
        ndiff = (DW+1)'(0) - diff;
        mag = diff[DW] ? ndiff[DW-1:0] : diff[DW-1:0];
        // dividing by 8*sd puts the three integer bits of |z| into the quotient
        sdiv = {sv[DW-2:0], 3'b000};
        in_fl.nonneg = !diff[DW];
        in_fl.bad = sv[DW-1] || (sv == '0);
        in_fl.tail = ({2'b00, mag} >= sdiv);
    end

    logic            in_v_reg;
    gcp_pkg::flags_t in_fl_reg;
    logic [DW-1:0]   in_mag_reg;
    logic [SW-1:0]   in_s_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (adv) begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_fl_reg  <= in_fl;
            in_mag_reg <= mag;
            in_s_reg   <= sdiv;
        end
    end

    // ---------------- |z| = |x-mean| / sd with 32 fraction bits
    logic                  dv1_v;
    logic [gcp_pkg::ZW-1:0] dv1_z;
    logic [FLW-1:0]        dv1_side;

    gcp_divu #(
        .RW (SW),
        .QW (gcp_pkg::ZW),
        .SBW(FLW)
    ) u_div_z (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (in_v_reg),
        .in_rem   (SW'(in_mag_reg)),
        .in_div   (in_s_reg),
        .in_side  (in_fl_reg),
        .out_valid(dv1_v),
        .out_quo  (dv1_z),
        .out_side (dv1_side)
    );

    // ---------------- denominator 1 + p|z| and w = z*z/2
    logic [64:0]                 cpz;
    logic [2*gcp_pkg::ZW-1:0]    zz;
    logic [33:0]                 den;
    logic                        den_v_reg;
    gcp_pkg::flags_t             den_fl_reg;
    logic [gcp_pkg::D2W-1:0]     den_d2_reg;
    logic [gcp_pkg::WW-1:0]      den_w_reg;

    always_comb begin
        cpz = 65'(gcp_pkg::CP[29:0]) * 65'(dv1_z);
        den = 34'(gcp_pkg::ONE) + 34'(cpz[64:32]);
        zz = dv1_z * dv1_z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            den_v_reg <= 1'b0;
        end else if (adv) begin
            den_v_reg <= dv1_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            den_fl_reg <= dv1_side;
            den_d2_reg <= {den, 1'b0};
            den_w_reg  <= zz[2*gcp_pkg::ZW-1:33];
        end
    end

    // ---------------- t = 2^64 / den, as 2^32 over twice the denominator
    logic                        dv2_v;
    logic [TW-1:0]               dv2_t;
    logic [FLW+gcp_pkg::WW-1:0]  dv2_side;

    gcp_divu #(
        .RW (gcp_pkg::D2W),
        .QW (TW),
        .SBW(FLW + gcp_pkg::WW)
    ) u_div_t (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (den_v_reg),
        .in_rem   (gcp_pkg::D2W'(gcp_pkg::ONE)),
        .in_div   (den_d2_reg),
        .in_side  ({den_fl_reg, den_w_reg}),
        .out_valid(dv2_v),
        .out_quo  (dv2_t),
        .out_side (dv2_side)
    );

    // ---------------- horner 1 and u = w*log2(e)
    logic [gcp_pkg::WW+32:0]         wl;
    logic                            hn1_v_reg;
    gcp_pkg::flags_t                 hn1_fl_reg;
    logic [TW-1:0]                   hn1_t_reg;
    logic [gcp_pkg::UW-1:0]          hn1_u_reg;
    logic signed [gcp_pkg::HW-1:0]   hn1_h_reg;

    assign wl = (gcp_pkg::WW+33)'(dv2_side[gcp_pkg::WW-1:0]) *
                (gcp_pkg::WW+33)'(gcp_pkg::CLOG2E[32:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hn1_v_reg <= 1'b0;
        end else if (adv) begin
            hn1_v_reg <= dv2_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hn1_fl_reg <= dv2_side[FLW+gcp_pkg::WW-1:gcp_pkg::WW];
            hn1_t_reg  <= dv2_t;
            hn1_u_reg  <= wl[gcp_pkg::UW+31:32];
            hn1_h_reg  <= gcp_pkg::tmul(dv2_t, gcp_pkg::HB5) - gcp_pkg::HB4;
        end
    end

    // ---------------- horner 2, range reduction: y = frac(u) * ln2
    logic [63:0]                     yl;
    logic                            hn2_v_reg;
    gcp_pkg::flags_t                 hn2_fl_reg;
    logic [TW-1:0]                   hn2_t_reg;
    logic [gcp_pkg::YW-1:0]          hn2_y_reg;
    logic [gcp_pkg::NW-1:0]          hn2_n_reg;
    logic signed [gcp_pkg::HW-1:0]   hn2_h_reg;

    assign yl = 64'(hn1_u_reg[31:0]) * 64'(gcp_pkg::CLN2[31:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hn2_v_reg <= 1'b0;
        end else if (adv) begin
            hn2_v_reg <= hn1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hn2_fl_reg <= hn1_fl_reg;
            hn2_t_reg  <= hn1_t_reg;
            hn2_y_reg  <= yl[63:32];
            hn2_n_reg  <= hn1_u_reg[gcp_pkg::UW-1:32];
            hn2_h_reg  <= gcp_pkg::tmul(hn1_t_reg, hn1_h_reg) + gcp_pkg::HB3;
        end
    end

    // ---------------- horner 3
    logic                            hn3_v_reg;
    gcp_pkg::flags_t                 hn3_fl_reg;
    logic [TW-1:0]                   hn3_t_reg;
    logic [gcp_pkg::YW-1:0]          hn3_y_reg;
    logic [gcp_pkg::NW-1:0]          hn3_n_reg;
    logic signed [gcp_pkg::HW-1:0]   hn3_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hn3_v_reg <= 1'b0;
        end else if (adv) begin
            hn3_v_reg <= hn2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hn3_fl_reg <= hn2_fl_reg;
            hn3_t_reg  <= hn2_t_reg;
            hn3_y_reg  <= hn2_y_reg;
            hn3_n_reg  <= hn2_n_reg;
            hn3_h_reg  <= gcp_pkg::tmul(hn2_t_reg, hn2_h_reg) - gcp_pkg::HB2;
        end
    end

    // ---------------- horner 4, negative polynomial clamps to zero
    logic signed [gcp_pkg::HW-1:0]   h4;
    logic                            hn4_v_reg;
    gcp_pkg::flags_t                 hn4_fl_reg;
    logic [TW-1:0]                   hn4_t_reg;
    logic [gcp_pkg::YW-1:0]          hn4_y_reg;
    logic [gcp_pkg::NW-1:0]          hn4_n_reg;
    logic [gcp_pkg::PW-1:0]          hn4_h_reg;

    assign h4 = gcp_pkg::tmul(hn3_t_reg, hn3_h_reg) + gcp_pkg::HB1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hn4_v_reg <= 1'b0;
        end else if (adv) begin
            hn4_v_reg <= hn3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hn4_fl_reg <= hn3_fl_reg;
            hn4_t_reg  <= hn3_t_reg;
            hn4_y_reg  <= hn3_y_reg;
            hn4_n_reg  <= hn3_n_reg;
            hn4_h_reg  <= h4[gcp_pkg::HW-1] ? '0 : h4[gcp_pkg::PW-1:0];
        end
    end

    // ---------------- taylor series of exp(-y), two stages per term
    typedef struct packed {
        gcp_pkg::flags_t          fl;
        logic [TW-1:0]            t;
        logic [gcp_pkg::PW-1:0]   h;
        logic [gcp_pkg::YW-1:0]   y;
        logic [gcp_pkg::NW-1:0]   n;
        logic [gcp_pkg::SUMW-1:0] pos;
        logic [gcp_pkg::SUMW-1:0] neg;
        logic [31:0]              p;
        logic [TW-1:0]            q;
    } tay_t;

    logic tm_v_reg [NT];
    tay_t tm_reg   [NT];
    logic tr_v_reg [NT];
    tay_t tr_reg   [NT];

    for (genvar g = 0; g < NT; g++) begin : g_term
        localparam int K = g + 1;
        localparam logic [RS:0] RK = (RS+1)'((64'd1 << RS) / K);

        tay_t                 mi;
        logic                 mvi;
        logic [TW-1:0]        qc;
        logic [TW+31:0]       pr;
        logic [RS+32:0]       rl;
        tay_t                 mo;
        tay_t                 ro;

        // term entering the multiply stage, with the previous sum updated
        if (g == 0) begin : g_first
            always_comb begin
                mi.fl  = hn4_fl_reg;
                mi.t   = hn4_t_reg;
                mi.h   = hn4_h_reg;
                mi.y   = hn4_y_reg;
                mi.n   = hn4_n_reg;
                mi.pos = gcp_pkg::SUMW'(gcp_pkg::ONE);
                mi.neg = '0;
                mi.p   = '0;
                mi.q   = '0;
                qc     = TW'(gcp_pkg::ONE);
            end
            assign mvi = hn4_v_reg;
        end else begin : g_rest
            always_comb begin
                mi = tr_reg[g-1];
                qc = gcp_pkg::div_fix(tr_reg[g-1].q, tr_reg[g-1].p, 4'(g));
                if (g % 2 == 1) begin
                    mi.neg = tr_reg[g-1].neg + gcp_pkg::SUMW'(qc);
                end else begin
                    mi.pos = tr_reg[g-1].pos + gcp_pkg::SUMW'(qc);
                end
            end
            assign mvi = tr_v_reg[g-1];
        end

        assign pr = (TW+32)'(qc) * (TW+32)'(mi.y);
        assign rl = (RS+33)'(tm_reg[g].p) * (RS+33)'(RK);

        always_comb begin
            mo = mi;
            mo.p = pr[63:32];
            ro = tm_reg[g];
            // estimate of p / k, at most one low
            ro.q = rl[RS+TW-1:RS];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tm_v_reg[g] <= 1'b0;
                tr_v_reg[g] <= 1'b0;
            end else if (adv) begin
                tm_v_reg[g] <= mvi;
                tr_v_reg[g] <= tm_v_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                tm_reg[g] <= mo;
                tr_reg[g] <= ro;
            end
        end
    end

    // ---------------- last term, exp = sum >> n
    logic [TW-1:0]            q13;
    logic [gcp_pkg::SUMW-1:0] negf;
    logic [gcp_pkg::SUMW-1:0] sumf;
    logic                     exp_v_reg;
    gcp_pkg::flags_t          exp_fl_reg;
    logic [TW-1:0]            exp_t_reg;
    logic [gcp_pkg::PW-1:0]   exp_h_reg;
    logic [gcp_pkg::EW-1:0]   exp_e_reg;

    always_comb begin
        q13 = gcp_pkg::div_fix(tr_reg[NT-1].q, tr_reg[NT-1].p, 4'(NT));
        negf = tr_reg[NT-1].neg + gcp_pkg::SUMW'(q13);
        sumf = tr_reg[NT-1].pos - negf;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_v_reg <= 1'b0;
        end else if (adv) begin
            exp_v_reg <= tr_v_reg[NT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            exp_fl_reg <= tr_reg[NT-1].fl;
            exp_t_reg  <= tr_reg[NT-1].t;
            exp_h_reg  <= tr_reg[NT-1].h;
            if (tr_reg[NT-1].n >= gcp_pkg::NW'(gcp_pkg::EXP_FLUSH)) begin
                exp_e_reg <= '0;
            end else begin
                exp_e_reg <= gcp_pkg::EW'(sumf >> tr_reg[NT-1].n);
            end
        end
    end

    // ---------------- c * exp
    logic [gcp_pkg::EW+31:0]  l1;
    logic                     pc_v_reg;
    gcp_pkg::flags_t          pc_fl_reg;
    logic [TW-1:0]            pc_t_reg;
    logic [gcp_pkg::PW-1:0]   pc_h_reg;
    logic [gcp_pkg::M1W-1:0]  pc_m_reg;

    assign l1 = (gcp_pkg::EW+32)'(exp_e_reg) * (gcp_pkg::EW+32)'(gcp_pkg::CC[31:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_v_reg <= 1'b0;
        end else if (adv) begin
            pc_v_reg <= exp_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pc_fl_reg <= exp_fl_reg;
            pc_t_reg  <= exp_t_reg;
            pc_h_reg  <= exp_h_reg;
            pc_m_reg  <= l1[gcp_pkg::M1W+31:32];
        end
    end

    // ---------------- times t
    logic [gcp_pkg::M1W+TW-1:0] l2;
    logic                       pt_v_reg;
    gcp_pkg::flags_t            pt_fl_reg;
    logic [gcp_pkg::PW-1:0]     pt_h_reg;
    logic [gcp_pkg::M2W-1:0]    pt_m_reg;

    assign l2 = (gcp_pkg::M1W+TW)'(pc_m_reg) * (gcp_pkg::M1W+TW)'(pc_t_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pt_v_reg <= 1'b0;
        end else if (adv) begin
            pt_v_reg <= pc_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pt_fl_reg <= pc_fl_reg;
            pt_h_reg  <= pc_h_reg;
            pt_m_reg  <= l2[gcp_pkg::M2W+31:32];
        end
    end

    // ---------------- times polynomial
    logic [gcp_pkg::M2W+gcp_pkg::PW-1:0] l3;
    logic                                ph_v_reg;
    gcp_pkg::flags_t                     ph_fl_reg;
    logic [gcp_pkg::QPW-1:0]             ph_q_reg;

    assign l3 = (gcp_pkg::M2W+gcp_pkg::PW)'(pt_m_reg) *
                (gcp_pkg::M2W+gcp_pkg::PW)'(pt_h_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_v_reg <= 1'b0;
        end else if (adv) begin
            ph_v_reg <= pt_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ph_fl_reg <= pt_fl_reg;
            ph_q_reg  <= l3[gcp_pkg::QPW+31:32];
        end
    end

    // ---------------- result select and output register
    localparam logic [gcp_pkg::QPW-1:0] ONE_Q = gcp_pkg::QPW'(gcp_pkg::ONE);
    logic [gcp_pkg::QPW-1:0] res;
    logic [31:0]             prob_next;
    logic                    m_tvalid_reg;
    logic [31:0]             m_tdata_reg;
    logic                    m_tuser_reg;

    always_comb begin
        // upper tail is one minus the product, lower tail the product
        if (ph_fl_reg.nonneg) begin
            res = (ph_q_reg > ONE_Q) ? '0 : ONE_Q - ph_q_reg;
        end else begin
            res = ph_q_reg;
        end
        if (ph_fl_reg.bad) begin
            prob_next = '0;
        end else if (ph_fl_reg.tail) begin
            prob_next = ph_fl_reg.nonneg ? '1 : '0;
        end else if (res > gcp_pkg::QPW'(32'hFFFF_FFFF)) begin
            prob_next = '1;
        end else begin
            prob_next = res[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= ph_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= prob_next;
            m_tuser_reg <= ph_fl_reg.bad;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // ---------------- checks
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("bad deviation result with nonzero probability");

    a_request_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> in_v_reg)
        else $error("accepted request missing from the first stage");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(in_v_reg) && $stable(exp_v_reg) && $stable(pc_m_reg))
        else $error("pipeline moved while the output was stalled");

    a_t_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hn1_v_reg |-> hn1_t_reg <= TW'(gcp_pkg::ONE))
        else $error("reciprocal t above one");

    a_exp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        exp_v_reg |-> exp_e_reg <= gcp_pkg::EW'(gcp_pkg::ONE))
        else $error("exp series above one");

endmodule
